/* hw/rtl/lsh_pkg.sv */
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared widths, register indexes, request kinds and the result entry type
// of the 3x3 laplacian sharpening filter.
// ----------------------------------------------------------------------------
package lsh_pkg;

  localparam int SAMPLE_W     = 8;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 12;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 12;
  localparam int CHAN_REG_W   = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  localparam logic [WIDTH_REG_W-1:0]  FRAME_WIDTH_RST   = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RST  = 12'd480;
  localparam logic [CHAN_REG_W-1:0]   CHANNEL_COUNT_RST = 3'd3;

  // request kind carried in tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic                last;
    logic [SAMPLE_W-1:0] value;
  } result_t;

endpackage

/* hw/rtl/laplacian_sharpen_3x3.sv */
// output path: a released result is registered in the compute stage, then in the output queue
//   before m_tvalid rises; its request arrives W*C + C samples after the centre sample
// throughput: one request per cycle while s_tready, set by one line ram read-modify-write
// reset: positions, pending count, window taps and output queue cleared; the line ram is
//   not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// 3x3 laplacian sharpening (5*centre minus four neighbours) over an
// interleaved 8-bit pixel stream, with line buffers in one ram.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3 #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lsh_pkg::SAMPLE_W-1:0]      s_tdata,   // [7:0] sample
  input  logic [0:0]                        s_tuser,   // [0] opcode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lsh_pkg::SAMPLE_W-1:0]      m_tdata,   // [7:0] result_sample
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [lsh_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lsh_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import lsh_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW         = $clog2(LINE_DEPTH);
  localparam int SW         = $clog2(LINE_DEPTH + 1);
  localparam int LW         = SW + 1;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int CHW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNW        = $clog2(MAX_CHANNELS + 1);
  localparam int HW         = HEIGHT_REG_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FPW        = $clog2(FIFO_DEPTH);
  localparam int FCW        = $clog2(FIFO_DEPTH + 1);

  // configuration
  logic [WIDTH_REG_W-1:0]  frame_width;
  logic [HEIGHT_REG_W-1:0] frame_height;
  logic [CHAN_REG_W-1:0]   channel_count;
  logic                    cfg_hit;

  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [CNW-1:0] c_eff;
  logic [SW-1:0]  stride;
  logic [LW-1:0]  lag;
  logic [XW-1:0]  w_last, w_last2;
  logic [HW-1:0]  h_last, h_last2;
  logic [CHW-1:0] c_last;

  // positions
  logic [AW-1:0]  in_k;
  logic [CHW-1:0] in_ch, out_ch;
  logic [XW-1:0]  in_x, out_x;
  logic [HW-1:0]  in_row, out_row;
  logic [LW-1:0]  pend;

  logic s_acc, is_data, in_at_zero, data_emit, flush_emit, emit;
  logic out_interior, out_last;

  // compute stage
  logic                s1_valid, s1_data, s1_emit, s1_inner, s1_last;
  logic [CHW-1:0]      s1_ch;
  logic [AW-1:0]       s1_k;
  logic [SAMPLE_W-1:0] s1_sample;

  logic [2*SAMPLE_W-1:0] rd_word;
  logic [SAMPLE_W-1:0]   rd_above, rd_cur;
  logic                  ram_we;

  logic [SAMPLE_W-1:0] win_up   [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] win_ctr  [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] win_left [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] win_down [MAX_CHANNELS];

  logic [11:0]         z_ctr, z_left, z_right, z_up, z_down, acc;
  logic [SAMPLE_W-1:0] sat_value;
  result_t             res;

  // output queue
  result_t        fifo_mem [FIFO_DEPTH];
  logic [FPW-1:0] wr_ptr, rd_ptr;
  logic [FCW-1:0] count;
  logic           push, pop;

  // effective frame geometry
  always_comb begin
    if (frame_width < 12'd3) begin
      w_eff = WW'(3);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    h_eff = (frame_height < 12'd3) ? 12'd3 : frame_height;
    if (channel_count == '0) begin
      c_eff = CNW'(1);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      c_eff = CNW'(MAX_CHANNELS);
    end else begin
      c_eff = CNW'(channel_count);
    end
    stride  = SW'(SW'(w_eff) * SW'(c_eff));
    lag     = LW'(stride) + LW'(c_eff);
    w_last  = XW'(w_eff - WW'(1));
    w_last2 = XW'(w_eff - WW'(2));
    h_last  = h_eff - 12'd1;
    h_last2 = h_eff - 12'd2;
    c_last  = CHW'(c_eff - CNW'(1));
  end

  always_comb begin
    unique case (cfg_index)
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_CHANNEL_COUNT: cfg_hit = cfg_we;
      default:                                              cfg_hit = 1'b0;
    endcase
  end

  assign s_acc      = s_tvalid & s_tready;
  assign is_data    = (s_tuser[0] == OP_SAMPLE);
  assign in_at_zero = (in_k == '0) && (in_row == '0);
  assign data_emit  = (pend == lag);
  assign flush_emit = in_at_zero && (pend != '0);
  assign emit       = is_data ? data_emit : flush_emit;

  assign out_interior = (out_row != '0) && (out_row <= h_last2) &&
                        (out_x != '0) && (out_x <= w_last2);
  assign out_last     = (out_row == h_last) && (out_x == w_last) && (out_ch == c_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FRAME_WIDTH_RST;
      frame_height  <= FRAME_HEIGHT_RST;
      channel_count <= CHANNEL_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   frame_width   <= cfg_wdata[WIDTH_REG_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_wdata[HEIGHT_REG_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_wdata[CHAN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      in_k    <= '0;
      in_ch   <= '0;
      in_x    <= '0;
      in_row  <= '0;
      out_ch  <= '0;
      out_x   <= '0;
      out_row <= '0;
      pend    <= '0;
    end else if (s_acc) begin
      if (is_data) begin
        if (in_ch == c_last) begin
          in_ch <= '0;
          if (in_x == w_last) begin
            in_x   <= '0;
            in_k   <= '0;
            in_row <= (in_row == h_last) ? '0 : in_row + 12'd1;
          end else begin
            in_x <= in_x + XW'(1);
            in_k <= in_k + AW'(1);
          end
        end else begin
          in_ch <= in_ch + CHW'(1);
          in_k  <= in_k + AW'(1);
        end
        if (!data_emit) begin
          pend <= pend + LW'(1);
        end
      end else if (flush_emit) begin
        pend <= pend - LW'(1);
      end
      if (emit) begin
        if (out_ch == c_last) begin
          out_ch <= '0;
          if (out_x == w_last) begin
            out_x   <= '0;
            out_row <= (out_row == h_last) ? '0 : out_row + 12'd1;
          end else begin
            out_x <= out_x + XW'(1);
          end
        end else begin
          out_ch <= out_ch + CHW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_data   <= is_data;
      s1_emit   <= emit;
      // left neighbour of this row needs two earlier pixels of the channel
      s1_inner  <= out_interior && (in_x >= XW'(2));
      s1_last   <= out_last;
      s1_ch     <= in_ch;
      s1_k      <= in_k;
      s1_sample <= s_tdata;
    end
  end

  // each entry holds {row above, current row}; the next touch of an entry is a
  // full row later, so the write-back never meets a read of the same address
  assign ram_we = s1_valid && s1_data;

  lsh_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_k),
    .wdata ({rd_cur, s1_sample}),
    .re    (s_acc),
    .raddr (in_k),
    .rdata (rd_word)
  );

  assign rd_above = rd_word[2*SAMPLE_W-1:SAMPLE_W];
  assign rd_cur   = rd_word[SAMPLE_W-1:0];

  always_comb begin
    z_ctr   = {4'b0000, win_ctr[s1_ch]};
    z_left  = {4'b0000, win_left[s1_ch]};
    z_right = {4'b0000, rd_cur};
    z_up    = {4'b0000, win_up[s1_ch]};
    z_down  = {4'b0000, win_down[s1_ch]};
    acc     = (z_ctr << 2) + z_ctr - z_left - z_right - z_up - z_down;
    if (acc[11]) begin
      sat_value = '0;
    end else if (acc[10:8] != 3'd0) begin
      sat_value = 8'hff;
    end else begin
      sat_value = acc[7:0];
    end
    res.value = (s1_data && s1_inner) ? sat_value : '0;
    res.last  = s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        win_up[i]   <= '0;
        win_ctr[i]  <= '0;
        win_left[i] <= '0;
        win_down[i] <= '0;
      end
    end else if (ram_we) begin
      win_up[s1_ch]   <= rd_above;
      win_left[s1_ch] <= win_ctr[s1_ch];
      win_ctr[s1_ch]  <= rd_cur;
      win_down[s1_ch] <= s1_sample;
    end
  end

  // output queue absorbs the result in flight while the consumer stalls
  assign push     = s1_valid && s1_emit;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign m_tdata  = fifo_mem[rd_ptr].value;
  assign m_tlast  = fifo_mem[rd_ptr].last;
  assign s_tready = (count + FCW'(push)) < FCW'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FPW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FPW'(1);
      end
      count <= count + FCW'(push) - FCW'(pop);
    end
  end

  a_pend_bounded: assert property (@(posedge clk) disable iff (rst)
    pend <= lag)
    else $error("pending count beyond output lag");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (32'(count) + 32'(push)) <= FIFO_DEPTH)
    else $error("output queue overflow");

  a_full_backlog_emits: assert property (@(posedge clk) disable iff (rst || cfg_we)
    s_acc && is_data && data_emit |=> s1_valid && s1_emit)
    else $error("sample with full backlog released no result");

  a_flush_midframe: assert property (@(posedge clk) disable iff (rst || cfg_we)
    s_acc && !is_data && !in_at_zero |=> !s1_emit)
    else $error("flush in mid-frame released a result");

endmodule

/* hw/rtl/lsh_ram.sv */
// ----------------------------------------------------------------------------
// lsh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
